FILE: sv/lfsc_pkg.sv
// Package for the line-follow speed and steering control unit.
// Holds widths, register indexes, mode codes, duty limits and the stage structs.
// Depends on nothing; every other file of the unit uses it.
`timescale 1ns / 1ps

package lfsc_pkg;

  // Field widths
  localparam int unsigned ModeW      = 3;
  localparam int unsigned LineW      = 8;
  localparam int unsigned SpeedW     = 16;
  localparam int unsigned DutyW      = 10;
  localparam int unsigned ServoW     = 7;
  localparam int unsigned SteerGainW = 8;
  localparam int unsigned SpeedGainW = 16;
  localparam int unsigned TableW     = 50;
  localparam int unsigned CfgAddrW   = 3;
  localparam int unsigned CfgDataW   = 50;
  localparam int unsigned InTdataW   = 32;
  localparam int unsigned OutTdataW  = 24;

  // Configuration register indexes
  localparam logic [CfgAddrW-1:0] RegCenterLine = 3'd0;
  localparam logic [CfgAddrW-1:0] RegSteerP     = 3'd1;
  localparam logic [CfgAddrW-1:0] RegSteerD     = 3'd2;
  localparam logic [CfgAddrW-1:0] RegSpeedP     = 3'd3;
  localparam logic [CfgAddrW-1:0] RegSpeedI     = 3'd4;
  localparam logic [CfgAddrW-1:0] RegSpeedD     = 3'd5;
  localparam logic [CfgAddrW-1:0] RegSpeedTable = 3'd6;
  localparam logic [CfgAddrW-1:0] RegHalted     = 3'd7;

  // Track modes
  localparam logic [ModeW-1:0] ModeStraight   = 3'd0;
  localparam logic [ModeW-1:0] ModeCurveEntry = 3'd1;
  localparam logic [ModeW-1:0] ModeSmallS     = 3'd2;
  localparam logic [ModeW-1:0] ModeBigS       = 3'd3;
  localparam logic [ModeW-1:0] ModeLineChange = 3'd4;

  // Duty limits and steering map
  localparam logic [DutyW-1:0] DutyMax = 10'd999;
  localparam int AngleMin   = -45;
  localparam int AngleMax   = 45;
  localparam int AngleMul   = 7;
  localparam int AngleDiv   = 18;
  localparam int AngleOfs   = 47;
  localparam int ServoMin   = 'h1E;
  localparam int ServoMax   = 'h40;
  // angle*7/18 for |angle| <= 45 as a multiply by a rounded-up reciprocal
  localparam int RecipShift = 10;
  localparam int AngleRecip = (AngleMul * (1 << RecipShift) + AngleDiv - 1) / AngleDiv;

  typedef struct packed {
    logic [LineW-1:0]      center_line;
    logic [SteerGainW-1:0] steer_p_gain;
    logic [SteerGainW-1:0] steer_d_gain;
    logic [SpeedGainW-1:0] speed_p_gain;
    logic [SpeedGainW-1:0] speed_i_gain;
    logic [SpeedGainW-1:0] speed_d_gain;
    logic [TableW-1:0]     speed_table;
    logic                  halted;
  } cfg_t;

  typedef struct packed {
    logic [ModeW-1:0]  track_mode;
    logic [LineW-1:0]  line_position;
    logic [SpeedW-1:0] measured_speed;
  } in_item_t;

  // Error and difference terms of one item
  typedef struct packed {
    logic               run;
    logic               pid;
    logic [DutyW-1:0]   fixed_duty;
    logic signed [8:0]  err;
    logic signed [9:0]  derr;
    logic signed [16:0] e0;
    logic signed [17:0] d0;
    logic signed [18:0] dd;
    logic [SpeedW-1:0]  speed;
  } diff_t;

  // Products of one item
  typedef struct packed {
    logic               run;
    logic               pid;
    logic [DutyW-1:0]   fixed_duty;
    logic signed [16:0] steer_p_term;
    logic signed [17:0] steer_d_term;
    logic signed [33:0] kp_term;
    logic signed [32:0] ki_term;
    logic signed [34:0] kd_term;
    logic [SpeedW-1:0]  speed;
  } prod_t;

  typedef struct packed {
    logic              updated;
    logic [DutyW-1:0]  motor_duty;
    logic [ServoW-1:0] servo_duty;
  } res_t;

endpackage

FILE: sv/lfsc_err_stage.sv
// Error stage: steering and speed errors, their differences and the error history.
// Depends on lfsc_pkg.
`timescale 1ns / 1ps

module lfsc_err_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lfsc_pkg::cfg_t     cfg_i,
  input  logic               valid_i,
  output logic               ready_o,
  input  lfsc_pkg::in_item_t item_i,
  output logic               valid_o,
  input  logic               ready_i,
  output lfsc_pkg::diff_t    item_o
);

  logic               valid_q;
  lfsc_pkg::diff_t    item_q, item_d;
  logic signed [8:0]  last_err_q;
  logic signed [16:0] e_prev_q, e_prev2_q;
  logic [lfsc_pkg::DutyW-1:0] entry;
  logic signed [17:0] d1;
  logic               take;

  assign ready_o = !valid_q || ready_i;
  assign take    = valid_i && ready_o;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  // Pick the table entry of the mode
  always_comb begin
    unique case (item_i.track_mode)
      lfsc_pkg::ModeStraight:   entry = cfg_i.speed_table[9:0];
      lfsc_pkg::ModeCurveEntry: entry = cfg_i.speed_table[19:10];
      lfsc_pkg::ModeSmallS:     entry = cfg_i.speed_table[29:20];
      lfsc_pkg::ModeBigS:       entry = cfg_i.speed_table[39:30];
      lfsc_pkg::ModeLineChange: entry = cfg_i.speed_table[49:40];
      default:                  entry = '0;
    endcase
  end

  // Form errors and differences against the history
  always_comb begin
    item_d.run = !cfg_i.halted && (item_i.track_mode <= lfsc_pkg::ModeLineChange);
    item_d.pid = item_i.track_mode >= lfsc_pkg::ModeSmallS;
    item_d.fixed_duty = (entry > lfsc_pkg::DutyMax) ? lfsc_pkg::DutyMax : entry;
    item_d.err  = $signed({1'b0, item_i.line_position}) - $signed({1'b0, cfg_i.center_line});
    item_d.derr = 10'(item_d.err) - 10'(last_err_q);
    item_d.e0   = $signed({7'b0, entry}) - $signed({1'b0, item_i.measured_speed});
    item_d.d0   = 18'(item_d.e0) - 18'(e_prev_q);
    d1          = 18'(e_prev_q) - 18'(e_prev2_q);
    item_d.dd   = 19'(item_d.d0) - 19'(d1);
    item_d.speed = item_i.measured_speed;
  end

  // Advance the stage; running items update the last steering error and, in PID modes, shift the speed error history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= 1'b0;
      last_err_q <= '0;
      e_prev_q   <= '0;
      e_prev2_q  <= '0;
    end else begin
      if (ready_o) begin
        valid_q <= valid_i;
      end
      if (take && item_d.run) begin
        last_err_q <= item_d.err;
        if (item_d.pid) begin
          e_prev2_q <= e_prev_q;
          e_prev_q  <= item_d.e0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
  end

endmodule

FILE: sv/lfsc_mul_stage.sv
// Product stage: steering PD and speed PID gain products, one multiplier per term.
// Depends on lfsc_pkg.
`timescale 1ns / 1ps

module lfsc_mul_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lfsc_pkg::cfg_t  cfg_i,
  input  logic            valid_i,
  output logic            ready_o,
  input  lfsc_pkg::diff_t item_i,
  output logic            valid_o,
  input  logic            ready_i,
  output lfsc_pkg::prod_t item_o
);

  logic            valid_q;
  lfsc_pkg::prod_t item_q, item_d;
  logic            take;

  assign ready_o = !valid_q || ready_i;
  assign take    = valid_i && ready_o;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  // Multiply each term by its gain
  always_comb begin
    item_d.run          = item_i.run;
    item_d.pid          = item_i.pid;
    item_d.fixed_duty   = item_i.fixed_duty;
    item_d.speed        = item_i.speed;
    item_d.steer_p_term = 17'(item_i.err) * 17'($signed({1'b0, cfg_i.steer_p_gain}));
    item_d.steer_d_term = 18'(item_i.derr) * 18'($signed({1'b0, cfg_i.steer_d_gain}));
    item_d.kp_term      = 34'(item_i.d0) * 34'($signed({1'b0, cfg_i.speed_p_gain}));
    item_d.ki_term      = 33'(item_i.e0) * 33'($signed({1'b0, cfg_i.speed_i_gain}));
    item_d.kd_term      = 35'(item_i.dd) * 35'($signed({1'b0, cfg_i.speed_d_gain}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
  end

endmodule

FILE: sv/lfsc_out_stage.sv
// Result stage: servo angle map, PID sum and clamp, held duties and result register.
// Depends on lfsc_pkg.
`timescale 1ns / 1ps

module lfsc_out_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  lfsc_pkg::prod_t item_i,
  output logic            valid_o,
  input  logic            ready_i,
  output lfsc_pkg::res_t  res_o
);

  logic                        valid_q;
  lfsc_pkg::res_t              res_q, res_d;
  logic [lfsc_pkg::ServoW-1:0] held_servo_q;
  logic [lfsc_pkg::DutyW-1:0]  held_motor_q;
  logic                        take;

  logic signed [18:0] pd, pd_sat;
  logic [5:0]         angle_mag;
  logic [14:0]        angle_scaled;
  logic [4:0]         angle_q;
  logic [7:0]         servo_raw, servo_clamped;
  logic signed [35:0] total;
  logic [lfsc_pkg::DutyW-1:0] pid_duty;

  assign ready_o = !valid_q || ready_i;
  assign take    = valid_i && ready_o;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  // Saturate the PD sum and map the angle to a servo duty
  always_comb begin
    pd = 19'(item_i.steer_p_term) + 19'(item_i.steer_d_term);
    if (pd < 19'(lfsc_pkg::AngleMin)) begin
      pd_sat = 19'(lfsc_pkg::AngleMin);
    end else if (pd > 19'(lfsc_pkg::AngleMax)) begin
      pd_sat = 19'(lfsc_pkg::AngleMax);
    end else begin
      pd_sat = pd;
    end
    angle_mag    = pd_sat[18] ? 6'(-pd_sat) : pd_sat[5:0];
    angle_scaled = 15'(angle_mag) * 15'(lfsc_pkg::AngleRecip);
    angle_q      = angle_scaled[14:lfsc_pkg::RecipShift];
    servo_raw    = pd_sat[18] ? 8'(lfsc_pkg::AngleOfs) - {3'b0, angle_q}
                              : 8'(lfsc_pkg::AngleOfs) + {3'b0, angle_q};
    if (servo_raw < 8'(lfsc_pkg::ServoMin)) begin
      servo_clamped = 8'(lfsc_pkg::ServoMin);
    end else if (servo_raw > 8'(lfsc_pkg::ServoMax)) begin
      servo_clamped = 8'(lfsc_pkg::ServoMax);
    end else begin
      servo_clamped = servo_raw;
    end
  end

  // Sum the PID terms with the speed feed and clamp to the duty range
  always_comb begin
    total = 36'(item_i.kp_term) + 36'(item_i.ki_term) + 36'(item_i.kd_term)
          + $signed({12'b0, item_i.speed, 8'b0});
    if (total <= 36'sd0) begin
      pid_duty = '0;
    end else if (total[35:8] > 28'(lfsc_pkg::DutyMax)) begin
      pid_duty = lfsc_pkg::DutyMax;
    end else begin
      pid_duty = total[17:8];
    end
  end

  // Choose fresh or held duties
  always_comb begin
    res_d.updated = item_i.run;
    if (item_i.run) begin
      res_d.servo_duty = servo_clamped[lfsc_pkg::ServoW-1:0];
      res_d.motor_duty = item_i.pid ? pid_duty : item_i.fixed_duty;
    end else begin
      res_d.servo_duty = held_servo_q;
      res_d.motor_duty = held_motor_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= 1'b0;
      held_servo_q <= '0;
      held_motor_q <= '0;
    end else begin
      if (ready_o) begin
        valid_q <= valid_i;
      end
      if (take && item_i.run) begin
        held_servo_q <= res_d.servo_duty;
        held_motor_q <= res_d.motor_duty;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
    end
  end

endmodule

FILE: sv/line_follow_speed_steer_control_unit.sv
// Top level of the line-follow speed and steering control unit.
// Depends on lfsc_pkg, lfsc_err_stage, lfsc_mul_stage and lfsc_out_stage.
//
//  channel   direction  handshake              payload
//  s_axis    in         tvalid / tready        track_mode, line_position, measured_speed
//  m_axis    out        tvalid / tready        servo_duty, motor_duty, updated
//  cfg       in         cfg_we_i (no stall)    register index, write data
//
// One item per cycle is accepted while the output is not stalled; the accepting edge
// loads the input register, and the item then passes the error stage, the product
// stage and the result register.
// Speed error history updates in the error stage, so items flow back to back.
// Reset clears the pipeline, the history and held duties, and sets halted.
// A stalled output stops only the stages behind it that are full.
`timescale 1ns / 1ps

module line_follow_speed_steer_control_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // [2:0] track_mode, [10:3] line_position, [26:11] measured_speed, rest zero
  input  logic [lfsc_pkg::InTdataW-1:0]     s_axis_tdata_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [6:0] servo_duty, [16:7] motor_duty, [17] updated, rest zero
  output logic [lfsc_pkg::OutTdataW-1:0]    m_axis_tdata_o,
  input  logic                              cfg_we_i,
  input  logic [lfsc_pkg::CfgAddrW-1:0]     cfg_addr_i,
  input  logic [lfsc_pkg::CfgDataW-1:0]     cfg_wdata_i
);

  lfsc_pkg::cfg_t     cfg_q;
  lfsc_pkg::in_item_t in_q;
  logic               in_valid_q;
  logic               in_ready;
  logic               err_valid, err_ready;
  lfsc_pkg::diff_t    err_item;
  logic               mul_valid, mul_ready;
  lfsc_pkg::prod_t    mul_item;
  logic               out_ready;
  lfsc_pkg::res_t     res;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= lfsc_pkg::cfg_t'{halted: 1'b1, default: '0};
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        lfsc_pkg::RegCenterLine: cfg_q.center_line  <= cfg_wdata_i[7:0];
        lfsc_pkg::RegSteerP:     cfg_q.steer_p_gain <= cfg_wdata_i[7:0];
        lfsc_pkg::RegSteerD:     cfg_q.steer_d_gain <= cfg_wdata_i[7:0];
        lfsc_pkg::RegSpeedP:     cfg_q.speed_p_gain <= cfg_wdata_i[15:0];
        lfsc_pkg::RegSpeedI:     cfg_q.speed_i_gain <= cfg_wdata_i[15:0];
        lfsc_pkg::RegSpeedD:     cfg_q.speed_d_gain <= cfg_wdata_i[15:0];
        lfsc_pkg::RegSpeedTable: cfg_q.speed_table  <= cfg_wdata_i[49:0];
        lfsc_pkg::RegHalted:     cfg_q.halted       <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Input register
  assign in_ready        = !in_valid_q || err_ready;
  assign s_axis_tready_o = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && in_ready) begin
      in_q.track_mode     <= s_axis_tdata_i[2:0];
      in_q.line_position  <= s_axis_tdata_i[10:3];
      in_q.measured_speed <= s_axis_tdata_i[26:11];
    end
  end

  lfsc_err_stage u_err (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (in_valid_q),
    .ready_o (err_ready),
    .item_i  (in_q),
    .valid_o (err_valid),
    .ready_i (mul_ready),
    .item_o  (err_item)
  );

  lfsc_mul_stage u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (err_valid),
    .ready_o (mul_ready),
    .item_i  (err_item),
    .valid_o (mul_valid),
    .ready_i (out_ready),
    .item_o  (mul_item)
  );

  lfsc_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mul_valid),
    .ready_o (out_ready),
    .item_i  (mul_item),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .res_o   (res)
  );

  // Pack the result item
  assign m_axis_tdata_o = {6'b0, res.updated, res.motor_duty, res.servo_duty};

endmodule

FILE: sv/lfsc_checker.sv
// Port-level checks for the line-follow speed and steering control unit.
// Depends on lfsc_pkg; bound to line_follow_speed_steer_control_unit.
`timescale 1ns / 1ps

module lfsc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [lfsc_pkg::OutTdataW-1:0] m_axis_tdata_o
);

  logic [lfsc_pkg::ServoW-1:0] last_servo_q;
  logic [lfsc_pkg::DutyW-1:0]  last_motor_q;

  // Track the duties of the last delivered item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_servo_q <= '0;
      last_motor_q <= '0;
    end else if (m_axis_tvalid_o && m_axis_tready_i) begin
      last_servo_q <= m_axis_tdata_o[6:0];
      last_motor_q <= m_axis_tdata_o[16:7];
    end
  end

  // A fresh servo duty lies in the servo range
  a_servo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[17] |->
      m_axis_tdata_o[6:0] >= 7'(lfsc_pkg::ServoMin) &&
      m_axis_tdata_o[6:0] <= 7'(lfsc_pkg::ServoMax))
    else $error("servo duty out of range on an updated item");

  // Motor duty never exceeds the limit
  a_motor_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[16:7] <= lfsc_pkg::DutyMax)
    else $error("motor duty above limit");

  // An item that does not update repeats the previous duties
  a_hold_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[17] |->
      m_axis_tdata_o[6:0] == last_servo_q && m_axis_tdata_o[16:7] == last_motor_q)
    else $error("held duties not repeated");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

endmodule

bind line_follow_speed_steer_control_unit lfsc_checker u_lfsc_checker (.*);
